@@ sv/chunk_residency_map_defines.svh @@
// Assertion macros shared by the chunk residency map RTL.
`ifndef CHUNK_RESIDENCY_MAP_DEFINES_SVH
`define CHUNK_RESIDENCY_MAP_DEFINES_SVH
`ifndef SYNTHESIS
`define CRM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define CRM_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define CRM_ASSERT(lbl, prop, msg)
`define CRM_NEVER(lbl, expr, msg)
`endif
`endif

@@ sv/crm_pkg.sv @@
// Package: sizes, command codes, controller states and command/status words.
`timescale 1ns / 1ps
package crm_pkg;
	localparam int CHUNK_BITS = 21;
	localparam int NUM_CHUNKS = 4096;
	localparam int WORD_W     = 64;
	localparam int WBITS      = 6;
	localparam int MAP_WORDS  = (NUM_CHUNKS + WORD_W - 1) / WORD_W;
	localparam int WA_W       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int IDX_W      = $clog2(NUM_CHUNKS);
	localparam int OFF_W      = 40;
	localparam int END_W      = OFF_W + 1;
	localparam int CFG_W      = 13;
	localparam int CW_A       = END_W - CHUNK_BITS + 1;
	localparam int CW         = (CW_A > 18) ? CW_A : 18;
	localparam int RB_W       = CW + CHUNK_BITS;
	localparam int CMP_W      = (RB_W > END_W) ? RB_W : END_W;

	typedef enum logic [1:0] {
		CMD_CHECK  = 2'd0,
		CMD_COMMIT = 2'd1,
		CMD_EVICT  = 2'd2
	} crm_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_FETCH,
		ST_WALK,
		ST_DONE
	} crm_state_t;

	typedef struct packed {
		logic capture;
		logic setup;
		logic rd_first;
		logic step;
		logic publish;
	} crm_cmd_t;

	typedef struct packed {
		logic walk;
		logic last;
		logic out_free;
	} crm_sts_t;
endpackage

@@ sv/crm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module crm_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ sv/crm_ctrl.sv @@
// Controller: sequences capture, range setup and the word-by-word map walk.
`timescale 1ns / 1ps
module crm_ctrl import crm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	input  crm_sts_t sts,
	output crm_cmd_t cmd
);
	crm_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_SETUP;
			end
			ST_SETUP: state_d = ST_FETCH;
			ST_FETCH: state_d = sts.walk ? ST_WALK : ST_DONE;
			ST_WALK: begin
				if (sts.last) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.capture = in_valid;
			end
			ST_SETUP: cmd.setup = 1'b1;
			ST_FETCH: cmd.rd_first = sts.walk;
			ST_WALK: cmd.step = 1'b1;
			ST_DONE: cmd.publish = sts.out_free;
			default: cmd = '0;
		endcase
	end
endmodule

@@ sv/crm_dpath.sv @@
// Datapath: range math, map RAM with per-word valid flags, and result register.
`timescale 1ns / 1ps
`include "chunk_residency_map_defines.svh"
module crm_dpath import crm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  crm_cmd_t         cmd,
	output crm_sts_t         sts,
	input  logic [1:0]       command,
	input  logic [OFF_W-1:0] byte_offset,
	input  logic [OFF_W-1:0] byte_length,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data,
	output logic             out_valid,
	output logic             ok,
	input  logic             out_stall
);
	localparam logic [WORD_W-1:0] ONES = {WORD_W{1'b1}};

	logic [CFG_W-1:0] reserved_q;
	crm_op_t          op_q;
	logic [OFF_W-1:0] off_q;
	logic [END_W-1:0] end_q;
	logic [IDX_W-1:0] st_q, last_q;
	logic [WA_W-1:0]  cur_q;
	logic             walk_q, ok_q, res_q;
	logic             out_valid_q;
	logic [MAP_WORDS-1:0] vld_q;

	logic [CW-1:0]    rc, up_end, dn_end, dn_off, up_off, st_c, ed_c, last_c;
	logic [CMP_W-1:0] rbytes;
	logic             in_range, ok_c, walk_c;
	logic [WA_W-1:0]  st_word, last_word, raddr;
	logic [WBITS-1:0] lo_bit, hi_bit;
	logic [WORD_W-1:0] rdata, eff, mask, wdata;
	logic             we, re;

	assign cfg_ready = 1'b1;

	always_comb begin
		rc = (CW'(reserved_q) > CW'(NUM_CHUNKS)) ? CW'(NUM_CHUNKS) : CW'(reserved_q);
		rbytes = CMP_W'(rc) << CHUNK_BITS;
		in_range = CMP_W'(end_q) <= rbytes;
		dn_end = CW'(end_q >> CHUNK_BITS);
		up_end = dn_end + CW'(|end_q[CHUNK_BITS-1:0]);
		dn_off = CW'(off_q >> CHUNK_BITS);
		up_off = dn_off + CW'(|off_q[CHUNK_BITS-1:0]);
		st_c = '0;
		ed_c = '0;
		ok_c = 1'b0;
		walk_c = 1'b0;
		case (op_q)
			CMD_CHECK, CMD_COMMIT: begin
				st_c = dn_off;
				ed_c = in_range ? up_end : rc;
				ok_c = dn_off < rc;
				walk_c = ok_c && (st_c < ed_c);
			end
			CMD_EVICT: begin
				st_c = up_off;
				ed_c = in_range ? dn_end : rc;
				ok_c = st_c < ed_c;
				walk_c = ok_c;
			end
			default: begin
				ok_c = 1'b0;
				walk_c = 1'b0;
			end
		endcase
		last_c = ed_c - CW'(1);
	end

	assign st_word   = WA_W'(st_q >> WBITS);
	assign last_word = WA_W'(last_q >> WBITS);
	assign lo_bit    = (cur_q == st_word) ? st_q[WBITS-1:0] : '0;
	assign hi_bit    = (cur_q == last_word) ? last_q[WBITS-1:0] : WBITS'(WORD_W - 1);
	assign mask      = (ONES << lo_bit) & (ONES >> (WBITS'(WORD_W - 1) - hi_bit));
	assign eff       = vld_q[cur_q] ? rdata : '0;
	assign wdata     = (op_q == CMD_COMMIT) ? (eff | mask) : (eff & ~mask);
	assign we        = cmd.step && (op_q != CMD_CHECK);
	assign re        = cmd.rd_first || (cmd.step && !sts.last);
	assign raddr     = cmd.step ? cur_q + WA_W'(1) : cur_q;

	assign sts.walk     = walk_q;
	assign sts.last     = cur_q == last_word;
	assign sts.out_free = !out_valid_q || !out_stall;

	crm_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAP_WORDS)
	) u_map (
		.clk  (clk),
		.we   (we),
		.waddr(cur_q),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reserved_q  <= CFG_W'(NUM_CHUNKS);
			vld_q       <= '0;
			walk_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) reserved_q <= cfg_data;
			if (we) vld_q[cur_q] <= 1'b1;
			if (cmd.setup) walk_q <= walk_c;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= crm_op_t'(command);
			off_q <= byte_offset;
			end_q <= {1'b0, byte_offset} + {1'b0, byte_length};
		end
		if (cmd.setup) begin
			st_q   <= IDX_W'(st_c);
			last_q <= IDX_W'(last_c);
			cur_q  <= WA_W'(st_c >> WBITS);
			ok_q   <= ok_c;
		end
		if (cmd.step) begin
			cur_q <= cur_q + WA_W'(1);
			if (op_q == CMD_CHECK) ok_q <= ok_q & ((eff & mask) == mask);
		end
		if (cmd.publish) res_q <= ok_q;
	end

	assign out_valid = out_valid_q;
	assign ok        = res_q;

	`CRM_ASSERT(a_walk_bound, cmd.step |-> (cur_q <= last_word), "walk ran past last word")
	`CRM_NEVER(a_check_no_write, cmd.step && (op_q == CMD_CHECK) && we, "check wrote the map")
	`CRM_ASSERT(a_write_in_mask, we |-> (((wdata ^ eff) & ~mask) == '0), "write outside range mask")
endmodule

@@ sv/chunk_residency_map.sv @@
// Top level: chunk residency map, one committed bit per chunk of the reserved range.
// Flow: capture, range setup, then for a non-empty, accepted range a first map read and a walk over the n map words
// it spans (up to 64), one RAM read a cycle plus a write for commit and evict; then ok is published.
// A new request is accepted only after the last ok is published, and may enter while that ok waits.
// Reset: async active low; per-word valid flags clear the map at once, reserved_chunks = 4096.
`timescale 1ns / 1ps
module chunk_residency_map import crm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [1:0]       command,
	input  logic [OFF_W-1:0] byte_offset,
	input  logic [OFF_W-1:0] byte_length,
	output logic             out_valid,
	input  logic             out_stall,
	output logic             ok,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);
	crm_cmd_t cmd;
	crm_sts_t sts;

	crm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	crm_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.command    (command),
		.byte_offset(byte_offset),
		.byte_length(byte_length),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.out_valid  (out_valid),
		.ok         (ok),
		.out_stall  (out_stall)
	);
endmodule
